// ===== rtl/c8ic_pkg.sv =====
// Shared types, opcode codes, font table and digit split for the CHIP-8 core.
// Depends on nothing; used by chip8_instruction_core and tb_top.
`default_nettype none

package c8ic_pkg;

  localparam int unsigned MemBytes   = 4096;
  localparam int unsigned MemAddrW   = 12;
  localparam int unsigned DispRows   = 32;
  localparam int unsigned DispCols   = 64;
  localparam int unsigned KeyTotal   = 16;
  localparam int unsigned FontBytes  = 80;
  localparam logic [11:0] PcReset    = 12'd512;

  // Item kinds carried on the request tuser
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_EXEC = 2'd1,
    OP_TICK = 2'd2,
    OP_READ = 2'd3
  } op_e;

  // Instruction groups (top nibble)
  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV  = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;
  localparam logic [3:0] GRP_MISC = 4'hF;

  localparam logic [15:0] INS_CLS = 16'h00E0;
  localparam logic [15:0] INS_RET = 16'h00EE;

  // Low-byte codes of the E and F groups
  localparam logic [7:0] KK_SKP   = 8'h9E;
  localparam logic [7:0] KK_SKNP  = 8'hA1;
  localparam logic [7:0] KK_GETDT = 8'h07;
  localparam logic [7:0] KK_WKEY  = 8'h0A;
  localparam logic [7:0] KK_SETDT = 8'h15;
  localparam logic [7:0] KK_SETST = 8'h18;
  localparam logic [7:0] KK_ADDI  = 8'h1E;
  localparam logic [7:0] KK_FONT  = 8'h29;
  localparam logic [7:0] KK_BCD   = 8'h33;
  localparam logic [7:0] KK_STORE = 8'h55;
  localparam logic [7:0] KK_LOAD  = 8'h65;

  // ALU sub-operations of the 8 group
  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  localparam logic [7:0] FONT [FontBytes] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h10, 8'h10, 8'h10,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Power-up content of one memory byte
  function automatic logic [7:0] init_byte(input logic [11:0] addr);
    logic [7:0] b;
    b = 8'h00;
    if (addr < 12'(FontBytes)) begin
      b = FONT[addr[6:0]];
    end
    return b;
  endfunction

  // Hundreds, tens and ones of a byte by compare and subtract
  function automatic logic [11:0] bcd_split(input logic [7:0] v);
    logic [1:0] h;
    logic [6:0] r;
    logic [3:0] t;
    logic [3:0] o;
    h = (v >= 8'd200) ? 2'd2 : (v >= 8'd100) ? 2'd1 : 2'd0;
    r = 7'(v - 8'(h) * 8'd100);
    t = 4'd0;
    for (int k = 9; k >= 1; k--) begin
      if (t == 4'd0 && r >= 7'(k * 10)) begin
        t = 4'(k);
      end
    end
    o = 4'(r - 7'(t) * 7'd10);
    return {o, t, 2'b00, h};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/c8ic_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module c8ic_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/chip8_instruction_core.sv =====
// CHIP-8 core top level: request decode, sequencer and the three state RAMs.
// Depends on c8ic_pkg and c8ic_ram.
`default_nettype none

// Usage:
//  Requests enter on s_axis: tuser is the item kind (load byte, execute,
//  timer tick, read display row), tdata carries the operands. Every request
//  yields exactly one response on m_axis with the PC, the sound flag, the
//  execute flags and the display row.
//  Main memory, the V registers and the display each live in a RAM with
//  registered read data; the sequencer reads, modifies and writes them back one
//  access at a time, so no two accesses to one entry overlap.
//  Loads and ticks go straight to the final step, a row read passes S_ROW,
//  and an execute fetches both bytes, reads Vx and Vy, then decodes. The
//  sprite row walk and the register block moves, one row or one register
//  at a time, take the longest.
//  After reset the core writes the font and zeros into all 4096 bytes of
//  main memory, one byte a cycle; s_axis_tready_o stays low until then.
//  A new request is taken while a response still waits on a stalled
//  m_axis; the core then holds in its final step until the response
//  register frees up.
module chip8_instruction_core #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // [11:0] load_address, [19:12] load_data, [35:20] key_mask,
  // [43:36] random_byte, [48:44] row_index, [55:49] zero
  input  wire logic [55:0] s_axis_tdata_i,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [11:0] program_counter, [12] sound_on, [13] invalid_instruction,
  // [14] stack_fault, [15] waiting_for_key, [79:16] row_pixels
  output      logic [79:0] m_axis_tdata_o
);

  localparam int unsigned LvlW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_FETCH_HI = 4'd2;
  localparam logic [3:0] S_FETCH_LO = 4'd3;
  localparam logic [3:0] S_READ_X   = 4'd4;
  localparam logic [3:0] S_READ_Y   = 4'd5;
  localparam logic [3:0] S_DECODE   = 4'd6;
  localparam logic [3:0] S_WRITE_X  = 4'd7;
  localparam logic [3:0] S_DRAW_RD  = 4'd8;
  localparam logic [3:0] S_DRAW_WR  = 4'd9;
  localparam logic [3:0] S_DRAW_END = 4'd10;
  localparam logic [3:0] S_BCD      = 4'd11;
  localparam logic [3:0] S_MOVE_RD  = 4'd12;
  localparam logic [3:0] S_MOVE_WR  = 4'd13;
  localparam logic [3:0] S_ROW      = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  logic [3:0]  state_q;
  logic [11:0] clr_cnt_q;
  logic        op_exec_q;
  logic [15:0] keys_q;
  logic [7:0]  rnd_q;
  logic [7:0]  op_hi_q;
  logic [15:0] op_q;
  logic [7:0]  vx_q;
  logic [7:0]  vy_q;
  logic [7:0]  res_q;
  logic [3:0]  cnt_q;
  logic        flag_q;
  logic [11:0] pc_q;
  logic [15:0] idx_q;
  logic [LvlW-1:0] lvl_q;
  logic [11:0] stk_q [STACK_DEPTH];
  logic [7:0]  dt_q;
  logic [7:0]  st_q;
  logic [15:0] vvld_q;
  logic [31:0] dvld_q;
  logic        vrd_vld_q;
  logic        drd_vld_q;
  logic        bad_q;
  logic        sf_q;
  logic        wait_q;
  logic [63:0] row_q;
  logic        out_vld_q;
  logic [79:0] out_q;

  // RAM ports
  logic        m_we;
  logic [11:0] m_waddr;
  logic [7:0]  m_wdata;
  logic [11:0] m_raddr;
  logic [7:0]  m_rdata;
  logic        v_we;
  logic [3:0]  v_waddr;
  logic [7:0]  v_wdata;
  logic [3:0]  v_raddr;
  logic [7:0]  v_rdata;
  logic        d_we;
  logic [4:0]  d_waddr;
  logic [63:0] d_wdata;
  logic [4:0]  d_raddr;
  logic [63:0] d_rdata;

  logic        accept;
  logic [1:0]  in_op;
  logic [3:0]  x;
  logic [3:0]  nsub;
  logic [7:0]  kk;
  logic [11:0] nnn;
  logic [7:0]  vy_w;
  logic [7:0]  vrd_w;
  logic [8:0]  draw_r;
  logic        draw_stop;
  logic [7:0]  spr_rev;
  logic [63:0] pat;
  logic [63:0] old_row;
  logic [7:0]  alu_res;
  logic        alu_flag;
  logic        alu_wf;
  logic        alu_ok;
  logic [8:0]  sum9;
  logic        key_down;
  logic        any_key;
  logic [3:0]  low_key;
  logic [11:0] bcd;
  logic [11:0] i_addr;
  logic        out_free;
  logic [3:0]  dec_next;

  c8ic_ram #(.WIDTH(8), .DEPTH(c8ic_pkg::MemBytes)) u_mem (
    .clk_i(clk_i), .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  c8ic_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
    .clk_i(clk_i), .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  c8ic_ram #(.WIDTH(c8ic_pkg::DispCols), .DEPTH(c8ic_pkg::DispRows)) u_disp (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op           = s_axis_tuser_i;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;
  assign out_free        = !out_vld_q || m_axis_tready_i;

  // Instruction fields and operands
  assign x      = op_q[11:8];
  assign nsub   = op_q[3:0];
  assign kk     = op_q[7:0];
  assign nnn    = op_q[11:0];
  assign vrd_w  = vrd_vld_q ? v_rdata : 8'h00;
  assign vy_w   = vrd_w;
  assign i_addr = idx_q[11:0] + {8'h00, cnt_q};
  assign bcd    = c8ic_pkg::bcd_split(vx_q);

  // Sprite row placement, clipped at the right edge by the shift
  assign draw_r    = {1'b0, vy_q} + {5'd0, cnt_q};
  assign draw_stop = (cnt_q == nsub) || (draw_r >= 9'(c8ic_pkg::DispRows));
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      spr_rev[j] = m_rdata[7-j];
    end
  end
  assign pat     = {56'd0, spr_rev} << vx_q;
  assign old_row = drd_vld_q ? d_rdata : 64'd0;

  // 8 group arithmetic; only the arithmetic and shift forms touch VF
  assign sum9 = {1'b0, vx_q} + {1'b0, vy_w};
  always_comb begin
    alu_res  = 8'h00;
    alu_flag = 1'b0;
    alu_wf   = 1'b0;
    alu_ok   = 1'b1;
    case (nsub)
      c8ic_pkg::ALU_MOV: alu_res = vy_w;
      c8ic_pkg::ALU_OR:  alu_res = vx_q | vy_w;
      c8ic_pkg::ALU_AND: alu_res = vx_q & vy_w;
      c8ic_pkg::ALU_XOR: alu_res = vx_q ^ vy_w;
      c8ic_pkg::ALU_ADD: begin
        alu_res  = sum9[7:0];
        alu_flag = sum9[8];
        alu_wf   = 1'b1;
      end
      c8ic_pkg::ALU_SUB: begin
        alu_res  = vx_q - vy_w;
        alu_flag = (vx_q >= vy_w);
        alu_wf   = 1'b1;
      end
      c8ic_pkg::ALU_SHR: begin
        alu_res  = {1'b0, vx_q[7:1]};
        alu_flag = vx_q[0];
        alu_wf   = 1'b1;
      end
      c8ic_pkg::ALU_SBN: begin
        alu_res  = vy_w - vx_q;
        alu_flag = (vy_w >= vx_q);
        alu_wf   = 1'b1;
      end
      c8ic_pkg::ALU_SHL: begin
        alu_res  = {vx_q[6:0], 1'b0};
        alu_flag = vx_q[7];
        alu_wf   = 1'b1;
      end
      default: alu_ok = 1'b0;
    endcase
  end

  // Key tests
  assign key_down = (vx_q < 8'(c8ic_pkg::KeyTotal)) && keys_q[vx_q[3:0]];
  assign any_key  = (keys_q != 16'h0000);
  always_comb begin
    low_key = 4'd0;
    for (int k = 15; k >= 0; k--) begin
      if (keys_q[k]) begin
        low_key = 4'(k);
      end
    end
  end

  // Step that follows decode
  always_comb begin
    dec_next = S_DONE;
    case (op_q[15:12])
      c8ic_pkg::GRP_ALU: dec_next = alu_ok ? S_WRITE_X : S_DONE;
      c8ic_pkg::GRP_DRW: dec_next = S_DRAW_RD;
      c8ic_pkg::GRP_MISC: begin
        if (kk == c8ic_pkg::KK_BCD) begin
          dec_next = S_BCD;
        end else if (kk inside {c8ic_pkg::KK_STORE, c8ic_pkg::KK_LOAD}) begin
          dec_next = S_MOVE_RD;
        end
      end
      default: ;
    endcase
  end

  // Main memory port selection
  always_comb begin
    m_we    = 1'b0;
    m_waddr = i_addr;
    m_wdata = vrd_w;
    m_raddr = pc_q;
    case (state_q)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_cnt_q;
        m_wdata = c8ic_pkg::init_byte(clr_cnt_q);
      end
      S_IDLE: begin
        m_we    = accept && (in_op == c8ic_pkg::OP_LOAD);
        m_waddr = s_axis_tdata_i[11:0];
        m_wdata = s_axis_tdata_i[19:12];
      end
      S_FETCH_LO: m_raddr = pc_q + 12'd1;
      S_DRAW_RD:  m_raddr = i_addr;
      S_MOVE_RD:  m_raddr = i_addr;
      S_BCD: begin
        m_we = 1'b1;
        case (cnt_q[1:0])
          2'd0:    m_wdata = {6'd0, bcd[1:0]};
          2'd1:    m_wdata = {4'd0, bcd[7:4]};
          default: m_wdata = {4'd0, bcd[11:8]};
        endcase
      end
      S_MOVE_WR: m_we = (kk == c8ic_pkg::KK_STORE);
      default: ;
    endcase
  end

  // Register file port selection
  always_comb begin
    v_we    = 1'b0;
    v_waddr = x;
    v_wdata = 8'h00;
    v_raddr = x;
    case (state_q)
      S_READ_X: v_raddr = op_hi_q[3:0];
      S_READ_Y: v_raddr = (op_q[15:12] == c8ic_pkg::GRP_JPV) ? 4'd0 : op_q[7:4];
      S_MOVE_RD: v_raddr = cnt_q;
      S_DECODE: begin
        case (op_q[15:12])
          c8ic_pkg::GRP_LD: begin
            v_we    = 1'b1;
            v_wdata = kk;
          end
          c8ic_pkg::GRP_ADD: begin
            v_we    = 1'b1;
            v_wdata = vx_q + kk;
          end
          c8ic_pkg::GRP_RND: begin
            v_we    = 1'b1;
            v_wdata = rnd_q & kk;
          end
          c8ic_pkg::GRP_ALU: begin
            v_we    = alu_wf;
            v_waddr = 4'hF;
            v_wdata = {7'd0, alu_flag};
          end
          c8ic_pkg::GRP_MISC: begin
            if (kk == c8ic_pkg::KK_GETDT) begin
              v_we    = 1'b1;
              v_wdata = dt_q;
            end else if (kk == c8ic_pkg::KK_WKEY) begin
              v_we    = any_key;
              v_wdata = {4'd0, low_key};
            end
          end
          default: ;
        endcase
      end
      S_WRITE_X: begin
        v_we    = 1'b1;
        v_wdata = res_q;
      end
      S_DRAW_END: begin
        v_we    = 1'b1;
        v_waddr = 4'hF;
        v_wdata = {7'd0, flag_q};
      end
      S_MOVE_WR: begin
        v_we    = (kk == c8ic_pkg::KK_LOAD);
        v_waddr = cnt_q;
        v_wdata = m_rdata;
      end
      default: ;
    endcase
  end

  // Display port selection
  always_comb begin
    d_we    = (state_q == S_DRAW_WR);
    d_waddr = draw_r[4:0];
    d_wdata = old_row ^ pat;
    d_raddr = (state_q == S_IDLE) ? s_axis_tdata_i[48:44] : draw_r[4:0];
  end

  // Sequencer and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= 12'd0;
      op_exec_q <= 1'b0;
      keys_q    <= 16'd0;
      rnd_q     <= 8'd0;
      op_hi_q   <= 8'd0;
      op_q      <= 16'd0;
      vx_q      <= 8'd0;
      vy_q      <= 8'd0;
      res_q     <= 8'd0;
      cnt_q     <= 4'd0;
      flag_q    <= 1'b0;
      pc_q      <= c8ic_pkg::PcReset;
      idx_q     <= 16'd0;
      lvl_q     <= '0;
      for (int k = 0; k < STACK_DEPTH; k++) begin
        stk_q[k] <= 12'd0;
      end
      dt_q      <= 8'd0;
      st_q      <= 8'd0;
      vvld_q    <= 16'd0;
      dvld_q    <= 32'd0;
      vrd_vld_q <= 1'b0;
      drd_vld_q <= 1'b0;
      bad_q     <= 1'b0;
      sf_q      <= 1'b0;
      wait_q    <= 1'b0;
      row_q     <= 64'd0;
      out_vld_q <= 1'b0;
      out_q     <= 80'd0;
    end else begin
      vrd_vld_q <= vvld_q[v_raddr];
      if (v_we) begin
        vvld_q[v_waddr] <= 1'b1;
      end
      if (d_we) begin
        dvld_q[d_waddr] <= 1'b1;
      end
      // Response register: loaded from the final step, dropped once taken
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 12'd1;
          if (clr_cnt_q == 12'(c8ic_pkg::MemBytes - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_exec_q <= (in_op == c8ic_pkg::OP_EXEC);
            keys_q    <= s_axis_tdata_i[35:20];
            rnd_q     <= s_axis_tdata_i[43:36];
            bad_q     <= 1'b0;
            sf_q      <= 1'b0;
            wait_q    <= 1'b0;
            row_q     <= 64'd0;
            drd_vld_q <= dvld_q[s_axis_tdata_i[48:44]];
            case (in_op)
              c8ic_pkg::OP_EXEC: state_q <= S_FETCH_HI;
              c8ic_pkg::OP_READ: state_q <= S_ROW;
              c8ic_pkg::OP_TICK: begin
                if (dt_q != 8'd0) dt_q <= dt_q - 8'd1;
                if (st_q != 8'd0) st_q <= st_q - 8'd1;
                state_q <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_ROW: begin
          row_q   <= old_row;
          state_q <= S_DONE;
        end
        S_FETCH_HI: state_q <= S_FETCH_LO;
        S_FETCH_LO: begin
          op_hi_q <= m_rdata;
          state_q <= S_READ_X;
        end
        S_READ_X: begin
          op_q    <= {op_hi_q, m_rdata};
          state_q <= S_READ_Y;
        end
        S_READ_Y: begin
          vx_q    <= vrd_w;
          state_q <= S_DECODE;
        end
        S_DECODE: begin
          vy_q    <= vy_w;
          cnt_q   <= 4'd0;
          flag_q  <= 1'b0;
          state_q <= dec_next;
          case (op_q[15:12])
            c8ic_pkg::GRP_SYS: begin
              if (op_q == c8ic_pkg::INS_CLS) begin
                dvld_q <= 32'd0;
                pc_q   <= pc_q + 12'd2;
              end else if (op_q == c8ic_pkg::INS_RET) begin
                if (lvl_q == '0) begin
                  sf_q <= 1'b1;
                end else begin
                  lvl_q <= lvl_q - 1'b1;
                  pc_q  <= stk_q[IdxW'(lvl_q - 1'b1)];
                end
              end else begin
                bad_q <= 1'b1;
              end
            end
            c8ic_pkg::GRP_JP: pc_q <= nnn;
            c8ic_pkg::GRP_CALL: begin
              if (lvl_q >= LvlW'(STACK_DEPTH)) begin
                sf_q <= 1'b1;
              end else begin
                stk_q[lvl_q[IdxW-1:0]] <= pc_q + 12'd2;
                lvl_q <= lvl_q + 1'b1;
                pc_q  <= nnn;
              end
            end
            c8ic_pkg::GRP_SE:   pc_q <= pc_q + ((vx_q == kk) ? 12'd4 : 12'd2);
            c8ic_pkg::GRP_SNE:  pc_q <= pc_q + ((vx_q != kk) ? 12'd4 : 12'd2);
            c8ic_pkg::GRP_SER:  pc_q <= pc_q + ((vx_q == vy_w) ? 12'd4 : 12'd2);
            c8ic_pkg::GRP_SNER: pc_q <= pc_q + ((vx_q != vy_w) ? 12'd4 : 12'd2);
            c8ic_pkg::GRP_ALU: begin
              pc_q  <= pc_q + 12'd2;
              res_q <= alu_res;
              if (!alu_ok) begin
                bad_q <= 1'b1;
              end
            end
            c8ic_pkg::GRP_LDI: begin
              idx_q <= {4'd0, nnn};
              pc_q  <= pc_q + 12'd2;
            end
            c8ic_pkg::GRP_JPV: pc_q <= {4'd0, vy_w} + nnn;
            c8ic_pkg::GRP_DRW: pc_q <= pc_q + 12'd2;
            c8ic_pkg::GRP_KEY: begin
              if (kk == c8ic_pkg::KK_SKP) begin
                pc_q <= pc_q + (key_down ? 12'd4 : 12'd2);
              end else if (kk == c8ic_pkg::KK_SKNP) begin
                pc_q <= pc_q + (key_down ? 12'd2 : 12'd4);
              end else begin
                bad_q <= 1'b1;
              end
            end
            c8ic_pkg::GRP_MISC: begin
              case (kk)
                c8ic_pkg::KK_GETDT: pc_q <= pc_q + 12'd2;
                c8ic_pkg::KK_WKEY: begin
                  if (any_key) pc_q <= pc_q + 12'd2;
                  else wait_q <= 1'b1;
                end
                c8ic_pkg::KK_SETDT: begin
                  dt_q <= vx_q;
                  pc_q <= pc_q + 12'd2;
                end
                c8ic_pkg::KK_SETST: begin
                  st_q <= vx_q;
                  pc_q <= pc_q + 12'd2;
                end
                c8ic_pkg::KK_ADDI: begin
                  idx_q <= idx_q + {8'd0, vx_q};
                  pc_q  <= pc_q + 12'd2;
                end
                c8ic_pkg::KK_FONT: begin
                  idx_q <= 16'({vx_q[3:0], 2'b00}) + {12'd0, vx_q[3:0]};
                  pc_q  <= pc_q + 12'd2;
                end
                c8ic_pkg::KK_BCD: pc_q <= pc_q + 12'd2;
                c8ic_pkg::KK_STORE, c8ic_pkg::KK_LOAD: pc_q <= pc_q + 12'd2;
                default: bad_q <= 1'b1;
              endcase
            end
            default: begin
              // 6xkk, 7xkk and Cxkk: the register write happens on the file port
              pc_q <= pc_q + 12'd2;
            end
          endcase
        end
        S_WRITE_X: state_q <= S_DONE;
        S_DRAW_RD: begin
          drd_vld_q <= dvld_q[draw_r[4:0]];
          state_q   <= draw_stop ? S_DRAW_END : S_DRAW_WR;
        end
        S_DRAW_WR: begin
          if ((old_row & pat) != 64'd0) flag_q <= 1'b1;
          cnt_q   <= cnt_q + 4'd1;
          state_q <= S_DRAW_RD;
        end
        S_DRAW_END: state_q <= S_DONE;
        S_BCD: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd2) state_q <= S_DONE;
        end
        S_MOVE_RD: state_q <= S_MOVE_WR;
        S_MOVE_WR: begin
          cnt_q   <= cnt_q + 4'd1;
          state_q <= (cnt_q == x) ? S_DONE : S_MOVE_RD;
        end
        S_DONE: begin
          if (out_free) begin
            out_q     <= {row_q, wait_q && op_exec_q, sf_q && op_exec_q,
                          bad_q && op_exec_q, st_q != 8'd0, pc_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_lvl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LvlW'(STACK_DEPTH))
    else $error("return stack level past its depth");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> $onehot0(m_axis_tdata_o[15:13]))
    else $error("more than one execute flag in a response");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready_o)
    else $error("request taken during memory initialization");

  a_pc_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !op_exec_q) |=> $stable(pc_q))
    else $error("PC changed by a non-execute request");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for chip8_instruction_core: streams load, execute, tick and
// read-row requests and compares every response with a behavioral machine model.
// Depends on c8ic_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] keys;
    logic [7:0]  rnd;
    logic [4:0]  row;
  } req_t;

  typedef struct packed {
    logic [63:0] pixels;
    logic        wait_key;
    logic        sfault;
    logic        bad;
    logic        sound;
    logic [11:0] pc;
  } rsp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [55:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [79:0] m_data;

  always #5 clk_i = ~clk_i;

  chip8_instruction_core i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data)
  );

  // Machine model state
  logic [7:0]  mem [c8ic_pkg::MemBytes];
  logic [7:0]  vreg [16];
  logic [15:0] idx;
  logic [11:0] pc;
  logic [11:0] stk [16];
  int unsigned sp;
  logic [7:0]  dt, st;
  logic [63:0] disp [c8ic_pkg::DispRows];

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   responses = 0;
  int   issued = 0;
  int   cycles = 0;
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_long = 0;
  bit   stim_done = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch #%0d %s: got %h want %h", responses, what, got, want);
    errors++;
  endtask

  function automatic void machine_reset();
    for (int a = 0; a < c8ic_pkg::MemBytes; a++) begin
      mem[a] = (a < c8ic_pkg::FontBytes) ? c8ic_pkg::FONT[a] : 8'h00;
    end
    for (int a = 0; a < 16; a++) begin
      vreg[a] = 8'h00;
      stk[a] = 12'h000;
    end
    for (int a = 0; a < c8ic_pkg::DispRows; a++) disp[a] = '0;
    idx = 16'h0000; pc = c8ic_pkg::PcReset; sp = 0; dt = 8'h00; st = 8'h00;
  endfunction

  function automatic void skip(input bit cond);
    pc = pc + (cond ? 12'd4 : 12'd2);
  endfunction

  // Execute the instruction at PC against the model
  function automatic void run_instr(input req_t q, inout rsp_t r);
    logic [15:0] ins;
    logic [3:0]  x, y, n;
    logic [7:0]  kk, a, b;
    logic [8:0]  sum;
    int          k;
    bit          down;
    logic [7:0]  bits;
    ins = {mem[pc], mem[pc + 12'd1]};
    x = ins[11:8]; y = ins[7:4]; n = ins[3:0]; kk = ins[7:0];
    case (ins[15:12])
      c8ic_pkg::GRP_SYS: begin
        if (ins == c8ic_pkg::INS_CLS) begin
          for (int i = 0; i < c8ic_pkg::DispRows; i++) disp[i] = '0;
          pc += 12'd2;
        end else if (ins == c8ic_pkg::INS_RET) begin
          if (sp == 0) r.sfault = 1'b1;
          else begin
            sp--;
            pc = stk[sp];
          end
        end else r.bad = 1'b1;
      end
      c8ic_pkg::GRP_JP: pc = ins[11:0];
      c8ic_pkg::GRP_CALL: begin
        if (sp >= 16) r.sfault = 1'b1;
        else begin
          stk[sp] = pc + 12'd2;
          sp++;
          pc = ins[11:0];
        end
      end
      c8ic_pkg::GRP_SE:   skip(vreg[x] == kk);
      c8ic_pkg::GRP_SNE:  skip(vreg[x] != kk);
      c8ic_pkg::GRP_SER:  skip(vreg[x] == vreg[y]);
      c8ic_pkg::GRP_LD:   begin vreg[x] = kk; pc += 12'd2; end
      c8ic_pkg::GRP_ADD:  begin vreg[x] = vreg[x] + kk; pc += 12'd2; end
      c8ic_pkg::GRP_ALU: begin
        a = vreg[x]; b = vreg[y];
        case (n)
          c8ic_pkg::ALU_MOV: vreg[x] = b;
          c8ic_pkg::ALU_OR:  vreg[x] = a | b;
          c8ic_pkg::ALU_AND: vreg[x] = a & b;
          c8ic_pkg::ALU_XOR: vreg[x] = a ^ b;
          c8ic_pkg::ALU_ADD: begin
            sum = {1'b0, a} + {1'b0, b};
            vreg[15] = {7'd0, sum[8]};
            vreg[x] = sum[7:0];
          end
          c8ic_pkg::ALU_SUB: begin vreg[15] = {7'd0, a >= b}; vreg[x] = a - b; end
          c8ic_pkg::ALU_SHR: begin vreg[15] = {7'd0, a[0]}; vreg[x] = a >> 1; end
          c8ic_pkg::ALU_SBN: begin vreg[15] = {7'd0, b >= a}; vreg[x] = b - a; end
          c8ic_pkg::ALU_SHL: begin vreg[15] = {7'd0, a[7]}; vreg[x] = a << 1; end
          default: r.bad = 1'b1;
        endcase
        pc += 12'd2;
      end
      c8ic_pkg::GRP_SNER: skip(vreg[x] != vreg[y]);
      c8ic_pkg::GRP_LDI:  begin idx = {4'd0, ins[11:0]}; pc += 12'd2; end
      c8ic_pkg::GRP_JPV:  pc = 12'(vreg[0]) + ins[11:0];
      c8ic_pkg::GRP_RND:  begin vreg[x] = q.rnd & kk; pc += 12'd2; end
      c8ic_pkg::GRP_DRW: begin
        a = vreg[x]; b = vreg[y];
        vreg[15] = 8'h00;
        for (int i = 0; i < n; i++) begin
          if (int'(b) + i >= c8ic_pkg::DispRows) break;
          bits = mem[12'(idx + 16'(i))];
          for (int j = 0; j < 8; j++) begin
            if (int'(a) + j >= c8ic_pkg::DispCols) break;
            if (bits[7 - j]) begin
              if (disp[int'(b) + i][int'(a) + j]) vreg[15] = 8'h01;
              disp[int'(b) + i][int'(a) + j] ^= 1'b1;
            end
          end
        end
        pc += 12'd2;
      end
      c8ic_pkg::GRP_KEY: begin
        down = vreg[x] < c8ic_pkg::KeyTotal && q.keys[vreg[x][3:0]];
        if (kk == c8ic_pkg::KK_SKP) skip(down);
        else if (kk == c8ic_pkg::KK_SKNP) skip(!down);
        else r.bad = 1'b1;
      end
      default: begin
        case (kk)
          c8ic_pkg::KK_GETDT: begin vreg[x] = dt; pc += 12'd2; end
          c8ic_pkg::KK_WKEY: begin
            k = -1;
            for (int i = 15; i >= 0; i--) if (q.keys[i]) k = i;
            if (k >= 0) begin vreg[x] = 8'(k); pc += 12'd2; end
            else r.wait_key = 1'b1;
          end
          c8ic_pkg::KK_SETDT: begin dt = vreg[x]; pc += 12'd2; end
          c8ic_pkg::KK_SETST: begin st = vreg[x]; pc += 12'd2; end
          c8ic_pkg::KK_ADDI:  begin idx = idx + 16'(vreg[x]); pc += 12'd2; end
          c8ic_pkg::KK_FONT:  begin idx = 16'(5 * vreg[x][3:0]); pc += 12'd2; end
          c8ic_pkg::KK_BCD: begin
            mem[12'(idx)]         = vreg[x] / 8'd100;
            mem[12'(idx + 16'd1)] = (vreg[x] / 8'd10) % 8'd10;
            mem[12'(idx + 16'd2)] = vreg[x] % 8'd10;
            pc += 12'd2;
          end
          c8ic_pkg::KK_STORE: begin
            for (int i = 0; i <= x; i++) mem[12'(idx + 16'(i))] = vreg[i];
            pc += 12'd2;
          end
          c8ic_pkg::KK_LOAD: begin
            for (int i = 0; i <= x; i++) vreg[i] = mem[12'(idx + 16'(i))];
            pc += 12'd2;
          end
          default: r.bad = 1'b1;
        endcase
      end
    endcase
  endfunction

  function automatic rsp_t predict_response(input req_t q);
    rsp_t r;
    r = '0;
    case (c8ic_pkg::op_e'(q.op))
      c8ic_pkg::OP_LOAD: mem[q.addr] = q.data;
      c8ic_pkg::OP_EXEC: run_instr(q, r);
      c8ic_pkg::OP_TICK: begin
        if (dt != 0) dt--;
        if (st != 0) st--;
      end
      default: r.pixels = disp[q.row];
    endcase
    r.pc = pc;
    r.sound = (st != 0);
    return r;
  endfunction

  // Stimulus helpers
  function automatic req_t mk(input c8ic_pkg::op_e op);
    req_t q;
    q.op = op;
    q.addr = 12'($urandom_range(0, 4095));
    q.data = 8'($urandom_range(0, 255));
    q.keys = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
    q.rnd = 8'($urandom_range(0, 255));
    q.row = 5'($urandom_range(0, 31));
    return q;
  endfunction

  // Load one instruction at the current model PC and queue its execution
  logic [11:0] stim_pc;
  task automatic put_instr(input logic [15:0] ins, input logic [15:0] keys);
    req_t q;
    q = mk(c8ic_pkg::OP_LOAD); q.addr = stim_pc; q.data = ins[15:8];
    pending_reqs.push_back(q);
    q = mk(c8ic_pkg::OP_LOAD); q.addr = stim_pc + 12'd1; q.data = ins[7:0];
    pending_reqs.push_back(q);
    q = mk(c8ic_pkg::OP_EXEC); q.keys = keys;
    pending_reqs.push_back(q);
  endtask

  // Plan a random instruction biased toward legal encodings
  function automatic logic [15:0] rand_instr();
    logic [15:0] ins;
    logic [7:0]  kks [11];
    kks = '{c8ic_pkg::KK_GETDT, c8ic_pkg::KK_WKEY, c8ic_pkg::KK_SETDT,
            c8ic_pkg::KK_SETST, c8ic_pkg::KK_ADDI, c8ic_pkg::KK_FONT,
            c8ic_pkg::KK_BCD, c8ic_pkg::KK_STORE, c8ic_pkg::KK_LOAD,
            c8ic_pkg::KK_SKP, c8ic_pkg::KK_SKNP};
    ins = 16'($urandom);
    case ($urandom_range(0, 9))
      0: ins = ($urandom_range(0, 1) == 1) ? c8ic_pkg::INS_CLS : c8ic_pkg::INS_RET;
      1: ins[15:12] = c8ic_pkg::GRP_ALU;
      2: begin
        ins[15:12] = c8ic_pkg::GRP_MISC;
        ins[7:0] = kks[$urandom_range(0, 8)];
      end
      3: begin
        ins[15:12] = c8ic_pkg::GRP_KEY;
        ins[7:0] = kks[$urandom_range(9, 10)];
      end
      4: begin ins[15:12] = c8ic_pkg::GRP_DRW; end
      5: begin ins[15:12] = c8ic_pkg::GRP_CALL; end
      default: ;
    endcase
    return ins;
  endfunction

  // Driver
  req_t cur;
  int   s_gap = 0;
  always @(posedge clk_i) begin
    if (s_valid && s_ready) begin
      expected_rsps.push_back(predict_response(cur));
    end
    if (!s_valid || s_ready) begin
      if (s_gap > 0) begin
        s_gap <= s_gap - 1;
        s_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur = pending_reqs.pop_front();
        issued++;
        s_valid <= 1'b1;
        s_user  <= cur.op;
        s_data  <= {7'd0, cur.row, cur.rnd, cur.keys, cur.data, cur.addr};
        if (!calm && $urandom_range(0, 9) == 0) s_gap <= int'($urandom_range(1, 17));
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold, counted down in its own process
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_long  <= 400;
    end else if (hold_long > 0) begin
      hold_long <= hold_long - 1;
    end
  end

  // Monitor and response-side stalls
  int m_gap = 0;
  always @(posedge clk_i) begin
    rsp_t got, want;
    if (m_valid && m_ready) begin
      got = rsp_t'(m_data);
      responses++;
      if (expected_rsps.size() == 0) report("unexpected response", 64'd0, 64'd0);
      else begin
        want = expected_rsps.pop_front();
        if (got.pc != want.pc) report("pc", 64'(got.pc), 64'(want.pc));
        if (got.sound != want.sound) report("sound_on", 64'(got.sound), 64'(want.sound));
        if (got.bad != want.bad) report("invalid", 64'(got.bad), 64'(want.bad));
        if (got.sfault != want.sfault) begin
          report("stack_fault", 64'(got.sfault), 64'(want.sfault));
        end
        if (got.wait_key != want.wait_key) begin
          report("wait_key", 64'(got.wait_key), 64'(want.wait_key));
        end
        if (got.pixels != want.pixels) report("row_pixels", got.pixels, want.pixels);
      end
    end
    if (hold_long > 0) begin
      m_ready <= 1'b0;
    end else if (m_gap > 0) begin
      m_gap <= m_gap - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) m_gap <= int'($urandom_range(1, 17));
    end
  end

  // Cycle limit: room for the memory clear, every request at its longest and both stalls
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("timeout with %0d responses outstanding", expected_rsps.size());
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    req_t q;
    machine_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part; the model PC is tracked by a scratch copy
    stim_pc = c8ic_pkg::PcReset;
    put_instr({c8ic_pkg::GRP_LD, 4'h0, 8'hFF}, 16'h0000);   stim_pc += 12'd2;
    put_instr({c8ic_pkg::GRP_LD, 4'h1, 8'h01}, 16'h0000);   stim_pc += 12'd2;
    put_instr({c8ic_pkg::GRP_ALU, 4'hF, 4'h0, c8ic_pkg::ALU_ADD}, 16'h0000);
    stim_pc += 12'd2;
    put_instr({c8ic_pkg::GRP_ALU, 4'h2, 4'h3, 4'h9}, 16'h0000); stim_pc += 12'd2;
    put_instr(16'h0123, 16'h0000);                      // invalid system, PC held
    put_instr(c8ic_pkg::INS_RET, 16'hFFFF);             // empty stack
    put_instr({c8ic_pkg::GRP_MISC, 4'h0, c8ic_pkg::KK_WKEY}, 16'h0000); // no key
    put_instr({c8ic_pkg::GRP_MISC, 4'h0, c8ic_pkg::KK_WKEY}, 16'h8000);
    stim_pc += 12'd2;
    put_instr({c8ic_pkg::GRP_LD, 4'h4, 8'd60}, 16'h0000);   stim_pc += 12'd2;
    put_instr({c8ic_pkg::GRP_LD, 4'h5, 8'd30}, 16'h0000);   stim_pc += 12'd2;
    put_instr({c8ic_pkg::GRP_MISC, 4'h0, c8ic_pkg::KK_FONT}, 16'h0000);
    stim_pc += 12'd2;
    put_instr({c8ic_pkg::GRP_DRW, 4'h4, 4'h5, 4'hF}, 16'h0000); stim_pc += 12'd2;
    q = mk(c8ic_pkg::OP_READ); q.row = 5'd31; pending_reqs.push_back(q);
    q = mk(c8ic_pkg::OP_READ); q.row = 5'd0;  pending_reqs.push_back(q);
    q = mk(c8ic_pkg::OP_TICK); pending_reqs.push_back(q);
    put_instr({c8ic_pkg::GRP_JP, 12'hFFE}, 16'h0000);
    stim_pc = 12'hFFE;
    put_instr({c8ic_pkg::GRP_MISC, 4'hF, c8ic_pkg::KK_STORE}, 16'hFFFF); // PC wraps
    while (pending_reqs.size() > 0 || issued != responses) @(posedge clk_i);

    // Long receiver hold while a burst of requests keeps coming
    hold_req = 1'b1;
    for (int k = 0; k < 6; k++) pending_reqs.push_back(mk(c8ic_pkg::OP_TICK));

    // Random part: programs built at the model PC, with stray loads, ticks and reads
    for (int it = 0; it < 480; it++) begin
      if (it > 420) calm = 1'b1;
      // Wait for the model to settle so the PC is known
      while (pending_reqs.size() > 0 || issued != responses) @(posedge clk_i);
      stim_pc = pc;
      case ($urandom_range(0, 9))
        0: pending_reqs.push_back(mk(c8ic_pkg::OP_TICK));
        1: pending_reqs.push_back(mk(c8ic_pkg::OP_READ));
        2: pending_reqs.push_back(mk(c8ic_pkg::OP_LOAD));
        default: begin
          put_instr(rand_instr(), ($urandom_range(0, 2) == 0) ? 16'h0 : 16'($urandom));
        end
      endcase
      if (it % 100 == 0) begin
        while (pending_reqs.size() > 0 || issued != responses) @(posedge clk_i);
        stim_pc = pc;
        put_instr(c8ic_pkg::INS_CLS, 16'h0000);
      end
    end
    while (pending_reqs.size() > 0 || issued != responses) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d responses of load, execute, tick and row-read requests", responses);
    if (errors == 0 && expected_rsps.size() == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/c8ic_pkg.sv
rtl/c8ic_ram.sv
rtl/chip8_instruction_core.sv
dv/tb_top.sv
